// ===== sv/nscc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and codes for the NMEA sentence checker and classifier.
// No dependencies.
package nscc_pkg;

   localparam int QUEUE_DEPTH = 2;

   localparam int INTERVAL_WIDTH = 16;
   localparam logic [INTERVAL_WIDTH-1:0] INTERVAL_RESET = 16'd100;

   localparam logic [1:0] REG_GGA_ENABLE      = 2'd0;
   localparam logic [1:0] REG_RMC_ENABLE      = 2'd1;
   localparam logic [1:0] REG_HDT_ENABLE      = 2'd2;
   localparam logic [1:0] REG_REPORT_INTERVAL = 2'd3;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_SHORT     = 2'd1;
   localparam logic [1:0] ST_MALFORMED = 2'd2;
   localparam logic [1:0] ST_MISMATCH  = 2'd3;

   localparam logic [1:0] KIND_NONE = 2'd0;
   localparam logic [1:0] KIND_GGA  = 2'd1;
   localparam logic [1:0] KIND_RMC  = 2'd2;
   localparam logic [1:0] KIND_HDT  = 2'd3;

   typedef struct packed {
      logic [1:0] status;
      logic [2:0] kind_match;
      logic [7:0] received_sum;
      logic [7:0] computed_sum;
   } summary_type;

   typedef struct packed {
      logic                      gga_enable;
      logic                      rmc_enable;
      logic                      hdt_enable;
      logic [INTERVAL_WIDTH-1:0] report_interval;
   } cfg_type;

endpackage

// ===== sv/nmea_sentence_check_classify.sv =====
`timescale 1ns / 1ps
// NMEA sentence checksum checker and classifier, top level.
// Takes one byte per cycle; a sentence's summary enters the queue on its last byte.
// The input stalls only on a last byte while the two-entry summary queue is full.
// Results leave via queue and output register at up to one per cycle unless rsp_stall holds.
// Synchronous reset clears the parser, queue, counters and output valid; registers
// return to GGA/RMC/HDT disabled and report interval 100. No clearing pass.
module nmea_sentence_check_classify #(
   parameter int BAD_COUNT_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_accepted,
   output logic [1:0]  rsp_sentence_kind,
   output logic [1:0]  rsp_check_status,
   output logic [7:0]  rsp_received_sum,
   output logic [7:0]  rsp_computed_sum,
   output logic [31:0] rsp_bad_total,
   output logic        rsp_warn_now,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   nscc_pkg::cfg_type     cfg_ff;
   nscc_pkg::summary_type push_data, pop_data;
   logic                  take, push, pop, q_full, q_empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gga_enable      <= 1'b0;
         cfg_ff.rmc_enable      <= 1'b0;
         cfg_ff.hdt_enable      <= 1'b0;
         cfg_ff.report_interval <= nscc_pkg::INTERVAL_RESET;
      end else if (csr_write) begin
         case (csr_index)
            nscc_pkg::REG_GGA_ENABLE: cfg_ff.gga_enable <= csr_data[0];
            nscc_pkg::REG_RMC_ENABLE: cfg_ff.rmc_enable <= csr_data[0];
            nscc_pkg::REG_HDT_ENABLE: cfg_ff.hdt_enable <= csr_data[0];
            nscc_pkg::REG_REPORT_INTERVAL: cfg_ff.report_interval <= csr_data;
            default: ;
         endcase
      end
   end

   assign req_stall = q_full && req_last_byte;
   assign take      = req_valid && !req_stall;

   nscc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .rx_byte   (req_rx_byte),
      .last_byte (req_last_byte),
      .push      (push),
      .summary   (push_data)
   );

   nscc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .full      (q_full),
      .empty     (q_empty)
   );

   nscc_back #(
      .BAD_COUNT_WIDTH (BAD_COUNT_WIDTH)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .q_empty           (q_empty),
      .q_data            (pop_data),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_accepted      (rsp_accepted),
      .rsp_sentence_kind (rsp_sentence_kind),
      .rsp_check_status  (rsp_check_status),
      .rsp_received_sum  (rsp_received_sum),
      .rsp_computed_sum  (rsp_computed_sum),
      .rsp_bad_total     (rsp_bad_total),
      .rsp_warn_now      (rsp_warn_now)
   );

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && q_full))
      else $error("summary pushed into a full queue");

   a_short_quiet: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_check_status == nscc_pkg::ST_SHORT)) |->
      (!rsp_warn_now && (rsp_sentence_kind == nscc_pkg::KIND_NONE)))
      else $error("short sentence raised a warning or a kind");

   a_accept_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_accepted == (rsp_sentence_kind != nscc_pkg::KIND_NONE)))
      else $error("accepted flag disagrees with sentence kind");

   a_fail_no_kind: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && ((rsp_check_status == nscc_pkg::ST_MALFORMED) ||
                     (rsp_check_status == nscc_pkg::ST_MISMATCH))) |->
      (rsp_sentence_kind == nscc_pkg::KIND_NONE))
      else $error("failed sentence carries a kind");

endmodule

// ===== sv/nscc_front.sv =====
`timescale 1ns / 1ps
// Byte parser: running XOR, checksum field check and kind match per sentence.
// Depends on nscc_pkg; emits one summary per sentence on its last byte.
module nscc_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 take,
   input  logic [7:0]           rx_byte,
   input  logic                 last_byte,
   output logic                 push,
   output nscc_pkg::summary_type summary
);

   localparam logic [1:0] PH_START = 2'd0;
   localparam logic [1:0] PH_BODY  = 2'd1;
   localparam logic [1:0] PH_HEX   = 2'd2;
   localparam logic [1:0] PH_TAIL  = 2'd3;

   localparam logic [31:0] GGA_TEXT = "GGA,";
   localparam logic [31:0] RMC_TEXT = "RMC,";
   localparam logic [31:0] HDT_TEXT = "HDT,";

   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_SPACE  = 8'h20;

   function automatic logic [7:0] text_byte(input logic [1:0] k, input logic [1:0] idx);
      logic [31:0] w;
      logic [7:0]  r;
      case (k)
         2'd0: w = GGA_TEXT;
         2'd1: w = RMC_TEXT;
         default: w = HDT_TEXT;
      endcase
      case (idx)
         2'd0: r = w[31:24];
         2'd1: r = w[23:16];
         2'd2: r = w[15:8];
         default: r = w[7:0];
      endcase
      return r;
   endfunction

   function automatic logic [4:0] hex_digit(input logic [7:0] b);
      logic [4:0] r;
      r = 5'd0;
      if (b inside {[8'h30:8'h39]}) begin
         r = {1'b1, 4'(b - 8'h30)};
      end else if (b inside {[8'h41:8'h46]}) begin
         r = {1'b1, 4'(b - 8'h37)};
      end else if (b inside {[8'h61:8'h66]}) begin
         r = {1'b1, 4'(b - 8'h57)};
      end
      return r;
   endfunction

   logic [1:0] phase_ff, phase_in;
   logic [7:0] xor_ff, xor_in;
   logic       frozen_ff, frozen_in;
   logic [7:0] hex_ff, hex_in;
   logic [1:0] digits_ff, digits_in;
   logic       bad_ff, bad_in;
   logic [2:0] pos_ff, pos_in;
   logic [2:0] match_ff, match_in;
   logic [4:0] dig;
   logic       in_body;
   logic [1:0] idx;

   always_comb begin
      phase_in  = phase_ff;
      xor_in    = xor_ff;
      frozen_in = frozen_ff;
      hex_in    = hex_ff;
      digits_in = digits_ff;
      bad_in    = bad_ff;
      pos_in    = pos_ff;
      match_in  = match_ff;
      dig       = hex_digit(rx_byte);
      idx       = 2'(pos_ff - 3'd3);
      in_body   = (phase_ff == PH_BODY) || ((phase_ff == PH_START) && (rx_byte != CH_DOLLAR));

      if ((pos_ff >= 3'd3) && (pos_ff <= 3'd6)) begin
         for (int k = 0; k < 3; k++) begin
            if (rx_byte != text_byte(2'(k), idx)) begin
               match_in[k] = 1'b0;
            end
         end
      end
      if (pos_ff != 3'd7) begin
         pos_in = pos_ff + 3'd1;
      end

      if (phase_ff == PH_START) begin
         phase_in = PH_BODY;
      end
      if (in_body) begin
         if (rx_byte == CH_STAR) begin
            phase_in = PH_HEX;
         end else if (rx_byte == CH_NUL) begin
            frozen_in = 1'b1;
         end else if (!frozen_ff) begin
            xor_in = xor_ff ^ rx_byte;
         end
      end

      if (phase_ff == PH_HEX) begin
         if (!dig[4]) begin
            bad_in   = 1'b1;
            phase_in = PH_TAIL;
         end else begin
            hex_in    = {hex_ff[3:0], dig[3:0]};
            digits_in = digits_ff + 2'd1;
            if (digits_ff != 2'd0) begin
               phase_in = PH_TAIL;
            end
         end
      end

      if (phase_ff == PH_TAIL) begin
         if ((rx_byte != CH_NUL) && (rx_byte != CH_SPACE) && !(rx_byte inside {[8'd9:8'd13]})) begin
            bad_in = 1'b1;
         end
      end

      summary.kind_match   = match_in;
      summary.computed_sum = xor_in;
      if (pos_ff < 3'd6) begin
         summary.status       = nscc_pkg::ST_SHORT;
         summary.received_sum = 8'd0;
      end else if ((phase_in != PH_TAIL) || bad_in) begin
         summary.status       = nscc_pkg::ST_MALFORMED;
         summary.received_sum = 8'd0;
      end else if (hex_in != xor_in) begin
         summary.status       = nscc_pkg::ST_MISMATCH;
         summary.received_sum = hex_in;
      end else begin
         summary.status       = nscc_pkg::ST_OK;
         summary.received_sum = hex_in;
      end
   end

   assign push = take && last_byte;

   always_ff @(posedge clock) begin
      if (reset || push) begin
         phase_ff  <= PH_START;
         xor_ff    <= 8'd0;
         frozen_ff <= 1'b0;
         hex_ff    <= 8'd0;
         digits_ff <= 2'd0;
         bad_ff    <= 1'b0;
         pos_ff    <= 3'd0;
         match_ff  <= 3'b111;
      end else if (take) begin
         phase_ff  <= phase_in;
         xor_ff    <= xor_in;
         frozen_ff <= frozen_in;
         hex_ff    <= hex_in;
         digits_ff <= digits_in;
         bad_ff    <= bad_in;
         pos_ff    <= pos_in;
         match_ff  <= match_in;
      end
   end

endmodule

// ===== sv/nscc_queue.sv =====
`timescale 1ns / 1ps
// Short summary queue between the parser and the result stage.
// Depends on nscc_pkg for the entry type and depth.
module nscc_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  nscc_pkg::summary_type push_data,
   input  logic                  pop,
   output nscc_pkg::summary_type pop_data,
   output logic                  full,
   output logic                  empty
);

   localparam int DEPTH  = nscc_pkg::QUEUE_DEPTH;
   localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);

   nscc_pkg::summary_type store [DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = store[rd_ff];

   always_comb begin
      wr_in    = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + PTR_W'(1);
      rd_in    = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + PTR_W'(1);
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store[wr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (do_push) begin
            wr_ff <= wr_in;
         end
         if (do_pop) begin
            rd_ff <= rd_in;
         end
         count_ff <= count_in;
      end
   end

endmodule

// ===== sv/nscc_back.sv =====
`timescale 1ns / 1ps
// Result stage: failure counter, warning countdown, kind selection, output register.
// Depends on nscc_pkg; fed from nscc_queue.
module nscc_back #(
   parameter int BAD_COUNT_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  nscc_pkg::cfg_type     cfg,
   input  logic                  q_empty,
   input  nscc_pkg::summary_type q_data,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_accepted,
   output logic [1:0]            rsp_sentence_kind,
   output logic [1:0]            rsp_check_status,
   output logic [7:0]            rsp_received_sum,
   output logic [7:0]            rsp_computed_sum,
   output logic [31:0]           rsp_bad_total,
   output logic                  rsp_warn_now
);

   localparam int IW = nscc_pkg::INTERVAL_WIDTH;

   logic [BAD_COUNT_WIDTH-1:0]    count_ff, count_in;
   logic [IW-1:0]                 countdown_ff, countdown_in;
   logic [BAD_COUNT_WIDTH+31:0]   count_wide;
   logic                          fail, warn;
   logic [1:0]                    kind;
   logic                          valid_ff;
   logic                          accepted_ff;
   logic [1:0]                    kind_ff, status_ff;
   logic [7:0]                    rsum_ff, csum_ff;
   logic [31:0]                   total_ff;
   logic                          warn_ff;

   assign pop = !q_empty && (!valid_ff || !rsp_stall);

   always_comb begin
      fail         = (q_data.status == nscc_pkg::ST_MALFORMED) ||
                     (q_data.status == nscc_pkg::ST_MISMATCH);
      count_in     = count_ff;
      countdown_in = countdown_ff;
      warn         = 1'b0;
      kind         = nscc_pkg::KIND_NONE;
      if (fail) begin
         if (count_ff != '1) begin
            count_in = count_ff + BAD_COUNT_WIDTH'(1);
         end
         if (countdown_ff == '0) begin
            warn         = 1'b1;
            countdown_in = (cfg.report_interval == '0) ? '0 : cfg.report_interval - IW'(1);
         end else begin
            countdown_in = countdown_ff - IW'(1);
         end
      end else if (q_data.status == nscc_pkg::ST_OK) begin
         if (q_data.kind_match[0] && cfg.gga_enable) begin
            kind = nscc_pkg::KIND_GGA;
         end else if (q_data.kind_match[1] && cfg.rmc_enable) begin
            kind = nscc_pkg::KIND_RMC;
         end else if (q_data.kind_match[2] && cfg.hdt_enable) begin
            kind = nscc_pkg::KIND_HDT;
         end
      end
      count_wide = {32'd0, count_in};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         countdown_ff <= '0;
         valid_ff     <= 1'b0;
      end else begin
         if (pop) begin
            count_ff     <= count_in;
            countdown_ff <= countdown_in;
            valid_ff     <= 1'b1;
         end else if (!rsp_stall) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         accepted_ff <= (kind != nscc_pkg::KIND_NONE);
         kind_ff     <= kind;
         status_ff   <= q_data.status;
         rsum_ff     <= q_data.received_sum;
         csum_ff     <= q_data.computed_sum;
         total_ff    <= count_wide[31:0];
         warn_ff     <= warn;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_accepted      = accepted_ff;
   assign rsp_sentence_kind = kind_ff;
   assign rsp_check_status  = status_ff;
   assign rsp_received_sum  = rsum_ff;
   assign rsp_computed_sum  = csum_ff;
   assign rsp_bad_total     = total_ff;
   assign rsp_warn_now      = warn_ff;

endmodule
